@@ rtl/core/nvr_pkg.sv @@
`default_nettype none

package nvr_pkg;

  localparam int COORD_W  = 16;
  localparam int DIR_W    = 8;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int NUM_W    = 13;
  localparam int METRIC_W = 53;

  // Widths of the metric terms, sized to the value ranges of the fields.
  localparam int SXD_W = DIR_W + DIFF_W;       // one s*d product, signed
  localparam int SD_W  = SXD_W + 1;            // s.d, signed
  localparam int S2_W  = 15;                   // one s*s square, unsigned
  localparam int SS_W  = 16;                   // |s|^2, unsigned
  localparam int D2_W  = 32;                   // one d*d square, unsigned
  localparam int DD_W  = 34;                   // |d|^2, unsigned
  localparam int TERM_W = 50;                  // |s|^2*|d|^2 and (s.d)^2

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam int unsigned MAX_VERTICES_DEF = 4096;

  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic signed [COORD_W-1:0] vert_z;
    logic                      last_vertex;
  } vert_t;

  typedef struct packed {
    logic [NUM_W-1:0] nearest_number;
    logic             found;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
  } cfg_t;

  // Per-item control that rides along with the arithmetic.
  typedef struct packed {
    logic             last;
    logic             counted;   // vertex lies within the list limit
    logic             has_vert;  // list holds at least one counted vertex
    logic             dir_ok;    // no direction component is zero
    logic [NUM_W-1:0] number;    // 1-based number of this vertex
  } item_ctl_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    item_ctl_t                ctl;
  } qent_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/nvr_stream_if.sv @@
`default_nettype none

interface nvr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nvr_front.sv @@
`default_nettype none

module nvr_front #(
  parameter int unsigned MAX_VERTICES = nvr_pkg::MAX_VERTICES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  nvr_stream_if.sink          vert,
  input  nvr_pkg::cfg_t       cfg_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output nvr_pkg::qent_t      ent_o
);
  import nvr_pkg::*;

  logic [NUM_W-1:0] count_q, count_d;
  logic [NUM_W-1:0] number;
  logic             counted;

  assign vert.ready = !q_full_i;
  assign push_o     = vert.valid && vert.ready;

  assign counted = count_q < NUM_W'(MAX_VERTICES);
  assign number  = count_q + NUM_W'(1);

  always_comb begin
    ent_o.dx = {vert.data.vert_x[COORD_W-1], vert.data.vert_x}
             - {cfg_i.origin_x[COORD_W-1], cfg_i.origin_x};
    ent_o.dy = {vert.data.vert_y[COORD_W-1], vert.data.vert_y}
             - {cfg_i.origin_y[COORD_W-1], cfg_i.origin_y};
    ent_o.dz = {vert.data.vert_z[COORD_W-1], vert.data.vert_z}
             - {cfg_i.origin_z[COORD_W-1], cfg_i.origin_z};
    ent_o.ctl.last     = vert.data.last_vertex;
    ent_o.ctl.counted  = counted;
    ent_o.ctl.has_vert = counted || (count_q != '0);
    ent_o.ctl.dir_ok   = (cfg_i.dir_x != '0) && (cfg_i.dir_y != '0) && (cfg_i.dir_z != '0);
    ent_o.ctl.number   = number;
  end

  // Restart the count at the end of a list; hold it past the limit.
  always_comb begin
    count_d = count_q;
    if (push_o) begin
      priority if (vert.data.last_vertex) begin
        count_d = '0;
      end else if (counted) begin
        count_d = number;
      end else begin
        count_d = count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nvr_queue.sv @@
`default_nettype none

module nvr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  nvr_pkg::qent_t      push_data_i,
  input  wire logic           pop_i,
  output nvr_pkg::qent_t      pop_data_o,
  output nvr_pkg::q_stat_t    stat_o
);
  import nvr_pkg::*;

  qent_t             mem_q [QDEPTH];
  logic [QA_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QA_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QLVL_W-1:0] level_q, level_d;
  logic              do_push, do_pop;

  assign stat_o.full  = level_q == QLVL_W'(QDEPTH);
  assign stat_o.empty = level_q == '0;
  assign stat_o.level = level_q;

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QA_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QA_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   level_d = level_q + QLVL_W'(1);
      2'b01:   level_d = level_q - QLVL_W'(1);
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nvr_back.sv @@
`default_nettype none

module nvr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  nvr_pkg::cfg_t       cfg_i,
  input  wire logic           q_empty_i,
  input  nvr_pkg::qent_t      q_data_i,
  output logic                pop_o,
  nvr_stream_if.source        res
);
  import nvr_pkg::*;

  typedef struct packed {
    logic signed [SXD_W-1:0] sxdx, sydy, szdz;
    logic [S2_W-1:0]         sx2, sy2, sz2;
    logic [D2_W-1:0]         dx2, dy2, dz2;
    item_ctl_t               ctl;
  } st1_t;

  typedef struct packed {
    logic [SS_W-1:0]        ss;
    logic [DD_W-1:0]        dd;
    logic signed [SD_W-1:0] sd;
    item_ctl_t              ctl;
  } st2_t;

  typedef struct packed {
    logic [TERM_W-1:0] ssdd;
    logic [TERM_W-1:0] sdsd;
    item_ctl_t         ctl;
  } st3_t;

  typedef struct packed {
    logic [METRIC_W-1:0] metric;
    item_ctl_t           ctl;
  } st4_t;

  logic    en;
  logic    v1_q, v2_q, v3_q, v4_q;
  st1_t    s1_q, s1_d;
  st2_t    s2_q, s2_d;
  st3_t    s3_q, s3_d;
  st4_t    s4_q, s4_d;
  logic [METRIC_W-1:0] best_metric_q, best_metric_d;
  logic [NUM_W-1:0]    best_number_q, best_number_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_data_q, out_data_d;

  // Advance the whole pipe unless a result sits unclaimed.
  assign en    = !out_valid_q || res.ready;
  assign pop_o = en && !q_empty_i;

  assign res.valid = out_valid_q;
  assign res.data  = out_data_q;

  // Stage 1: the nine products.
  always_comb begin
    logic signed [2*DIR_W-1:0]  tsx, tsy, tsz;
    logic signed [2*DIFF_W-1:0] tdx, tdy, tdz;
    tsx = cfg_i.dir_x * cfg_i.dir_x;
    tsy = cfg_i.dir_y * cfg_i.dir_y;
    tsz = cfg_i.dir_z * cfg_i.dir_z;
    tdx = q_data_i.dx * q_data_i.dx;
    tdy = q_data_i.dy * q_data_i.dy;
    tdz = q_data_i.dz * q_data_i.dz;
    s1_d.sxdx = cfg_i.dir_x * q_data_i.dx;
    s1_d.sydy = cfg_i.dir_y * q_data_i.dy;
    s1_d.szdz = cfg_i.dir_z * q_data_i.dz;
    s1_d.sx2  = tsx[S2_W-1:0];
    s1_d.sy2  = tsy[S2_W-1:0];
    s1_d.sz2  = tsz[S2_W-1:0];
    s1_d.dx2  = tdx[D2_W-1:0];
    s1_d.dy2  = tdy[D2_W-1:0];
    s1_d.dz2  = tdz[D2_W-1:0];
    s1_d.ctl  = q_data_i.ctl;
  end

  // Stage 2: the three sums.
  always_comb begin
    s2_d.ss = {{(SS_W-S2_W){1'b0}}, s1_q.sx2} + {{(SS_W-S2_W){1'b0}}, s1_q.sy2}
            + {{(SS_W-S2_W){1'b0}}, s1_q.sz2};
    s2_d.dd = {2'b00, s1_q.dx2} + {2'b00, s1_q.dy2} + {2'b00, s1_q.dz2};
    s2_d.sd = {s1_q.sxdx[SXD_W-1], s1_q.sxdx}
            + {s1_q.sydy[SXD_W-1], s1_q.sydy}
            + {s1_q.szdz[SXD_W-1], s1_q.szdz};
    s2_d.ctl = s1_q.ctl;
  end

  // Stage 3: the two wide products.
  always_comb begin
    logic [SS_W+DD_W-1:0]       tp;
    logic signed [2*SD_W-1:0]   tq;
    tp = s2_q.ss * s2_q.dd;
    tq = s2_q.sd * s2_q.sd;
    s3_d.ssdd = tp[TERM_W-1:0];
    s3_d.sdsd = tq[TERM_W-1:0];
    s3_d.ctl  = s2_q.ctl;
  end

  // Stage 4: the difference, never negative.
  always_comb begin
    s4_d.metric = {{(METRIC_W-TERM_W){1'b0}}, s3_q.ssdd}
                - {{(METRIC_W-TERM_W){1'b0}}, s3_q.sdsd};
    s4_d.ctl    = s3_q.ctl;
  end

  // Running compare; strict less keeps the earliest of equal vertices.
  always_comb begin
    logic upd;
    logic fnd;
    logic [NUM_W-1:0] nb;
    upd = s4_q.ctl.counted && (s4_q.metric < best_metric_q);
    nb  = upd ? s4_q.ctl.number : best_number_q;
    fnd = s4_q.ctl.dir_ok && s4_q.ctl.has_vert;
    best_metric_d = best_metric_q;
    best_number_d = best_number_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    if (en) begin
      out_valid_d = v4_q && s4_q.ctl.last;
      if (v4_q) begin
        priority if (s4_q.ctl.last) begin
          out_data_d.found          = fnd;
          out_data_d.nearest_number = fnd ? nb : '0;
          best_metric_d             = '1;
          best_number_d             = '0;
        end else if (upd) begin
          best_metric_d = s4_q.metric;
          best_number_d = s4_q.ctl.number;
        end else begin
          best_metric_d = best_metric_q;
          best_number_d = best_number_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      v4_q          <= 1'b0;
      out_valid_q   <= 1'b0;
      best_metric_q <= '1;
      best_number_q <= '0;
    end else begin
      if (en) begin
        v1_q <= !q_empty_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      out_valid_q   <= out_valid_d;
      best_metric_q <= best_metric_d;
      best_number_q <= best_number_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nearest_vertex_to_ray.sv @@
// nearest_vertex_to_ray: picks, from a streamed list of Q8.8 vertices, the one
// nearest to the line through the configured origin along the configured
// direction, and reports its 1-based number at the end of the list.
// Channels: vert_i carries one vertex per transfer (x, y, z, last_vertex);
// result_o carries one result (nearest_number, found) for every vertex that
// has last_vertex set. found is 0, and the number 0, when a direction
// component is zero or no vertex was counted. Vertices past MAX_VERTICES in
// one list are not counted, but their last_vertex mark still ends the list.
// Throughput: one vertex per cycle while result_o is not held, set by the
// four-stage metric pipe and the running compare at its end.
// Path: the last vertex passes the queue, the four metric stages and the result
// register before its result is valid; a backed-up queue holds it longer.
// Stall: while result_o is held, the metric pipe freezes and the 4-entry
// queue keeps taking vertices until it fills; then vert_i.ready drops.
// Reset: clears the queue, the pipe, the running best and the list count,
// and loads the registers with origin 0 and direction (0, 0, 127).
// Write the registers through cfg_we_i/cfg_idx_i/cfg_data_i only while idle.
`default_nettype none

module nearest_vertex_to_ray #(
  parameter int unsigned MAX_VERTICES = nvr_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nvr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nvr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nvr_stream_if.sink                          vert_i,
  nvr_stream_if.source                        result_o
);
  import nvr_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    push;
  qent_t   push_ent;
  logic    pop;
  qent_t   pop_ent;
  q_stat_t q_stat;

  // Register file: one write per cycle, unknown indexes drop the write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X: cfg_d.origin_x = cfg_data_i;
        CFG_ORIGIN_Y: cfg_d.origin_y = cfg_data_i;
        CFG_ORIGIN_Z: cfg_d.origin_z = cfg_data_i;
        CFG_DIR_X:    cfg_d.dir_x    = cfg_data_i[DIR_W-1:0];
        CFG_DIR_Y:    cfg_d.dir_y    = cfg_data_i[DIR_W-1:0];
        CFG_DIR_Z:    cfg_d.dir_z    = cfg_data_i[DIR_W-1:0];
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.origin_z <= '0;
      cfg_q.dir_x    <= '0;
      cfg_q.dir_y    <= '0;
      cfg_q.dir_z    <= DIR_W'(127);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: take vertices, form p - r, count and tag them.
  nvr_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vert     (vert_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .ent_o    (push_ent)
  );

  // Queue: decouple the front from a stalled back end.
  nvr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_ent),
    .pop_i       (pop),
    .pop_data_o  (pop_ent),
    .stat_o      (q_stat)
  );

  // Back: metric pipe, running best and result register.
  nvr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_stat.empty),
    .q_data_i  (pop_ent),
    .pop_o     (pop),
    .res       (result_o)
  );

`ifndef SYNTH
  a_found_has_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.found |->
      (result_o.data.nearest_number != '0) &&
      (result_o.data.nearest_number <= NUM_W'(MAX_VERTICES)))
    else $error("found result without a valid vertex number");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.data.found |-> result_o.data.nearest_number == '0)
    else $error("not-found result carries a nonzero number");

  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= QLVL_W'(QDEPTH))
    else $error("queue level beyond its depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |=> !push || ($past(pop) && !q_stat.full) || !q_stat.full)
    else $error("vertex taken while queue full");
`endif

endmodule

`default_nettype wire

@@ dv/nearest_vertex_to_ray_tb.sv @@
`timescale 1ns / 100ps

module nearest_vertex_to_ray_tb;
  import nvr_pkg::*;

  localparam int unsigned LIST_LIMIT    = MAX_VERTICES_DEF;
  localparam int unsigned SETTLE_CYCLES = 12;      // pipe latency plus slack
  localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned REPORT_MAX    = 10;

  localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7fff;
  localparam logic signed [DIR_W-1:0]   D_MIN = 8'sh80;
  localparam logic signed [DIR_W-1:0]   D_MAX = 8'sh7f;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nvr_stream_if #(.T(vert_t))   vert_if ();
  nvr_stream_if #(.T(result_t)) pick_if ();

  nearest_vertex_to_ray dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vert_i     (vert_if),
    .result_o   (pick_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the ray registers and of the running search over one list.
  cfg_t                ray_cfg;
  logic [METRIC_W-1:0] best_metric;
  logic [NUM_W-1:0]    best_number;
  int unsigned         list_count;
  result_t             expected_picks[$];
  vert_t               prev_vertex;

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_active = 1'b0;
  event        hold_off_go;

  function automatic void open_list();
    best_metric = '1;
    best_number = '0;
    list_count  = 0;
  endfunction

  // Fold one accepted vertex into the running search; on the list end push
  // the pick the block must report. The metric is |s|^2*|d|^2 - (s.d)^2,
  // exact in 64 bits and kept at the block's metric width.
  function automatic void track_vertex(input vert_t v);
    longint  sx, sy, sz, dx, dy, dz;
    logic [METRIC_W-1:0] metric;
    result_t pick;
    sx = longint'(ray_cfg.dir_x);
    sy = longint'(ray_cfg.dir_y);
    sz = longint'(ray_cfg.dir_z);
    // Vertices past the list limit are dropped, but their end mark still counts.
    if (list_count < LIST_LIMIT) begin
      dx = longint'(v.vert_x) - longint'(ray_cfg.origin_x);
      dy = longint'(v.vert_y) - longint'(ray_cfg.origin_y);
      dz = longint'(v.vert_z) - longint'(ray_cfg.origin_z);
      metric = METRIC_W'((sx * sx + sy * sy + sz * sz) * (dx * dx + dy * dy + dz * dz)
                         - (sx * dx + sy * dy + sz * dz) ** 2);
      list_count++;
      // Strictly smaller only: the earliest of equal vertices stays.
      if (metric < best_metric) begin
        best_metric = metric;
        best_number = NUM_W'(list_count);
      end
    end
    if (v.last_vertex) begin
      // A zero direction component at the list end means not found.
      pick.found          = (sx != 0) && (sy != 0) && (sz != 0) && (list_count != 0);
      pick.nearest_number = pick.found ? best_number : '0;
      expected_picks.push_back(pick);
      open_list();
    end
  endfunction

  function automatic vert_t mk_vertex(input logic signed [COORD_W-1:0] x, y, z,
                                      input logic last);
    vert_t v;
    v.vert_x      = x;
    v.vert_y      = y;
    v.vert_z      = z;
    v.last_vertex = last;
    return v;
  endfunction

  // Mostly points scattered near the ray so the compare sees close calls,
  // some anywhere in the field range, some repeats to force ties.
  function automatic vert_t random_vertex(input logic last);
    vert_t v;
    int    t;
    t = int'($urandom_range(400)) - 200;
    case ($urandom_range(7))
      0, 1: v = mk_vertex(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), last);
      2: begin
        v = prev_vertex;
        v.last_vertex = last;
      end
      default: v = mk_vertex(
        COORD_W'(int'(ray_cfg.origin_x) + t * int'(ray_cfg.dir_x) + int'($urandom_range(16)) - 8),
        COORD_W'(int'(ray_cfg.origin_y) + t * int'(ray_cfg.dir_y) + int'($urandom_range(16)) - 8),
        COORD_W'(int'(ray_cfg.origin_z) + t * int'(ray_cfg.dir_z) + int'($urandom_range(16)) - 8),
        last);
    endcase
    prev_vertex = v;
    return v;
  endfunction

  function automatic void log_mismatch(input string what, input result_t want,
                                       input result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0t] %s: expected number %0d found %0b, got number %0d found %0b",
               $realtime, what, want.nearest_number, want.found,
               got.nearest_number, got.found);
  endfunction

  // Offer one vertex, with random idle cycles ahead of it, and hold it until
  // the transfer happens. Idle cycles carry junk on the data lines.
  task automatic send_vertex(input vert_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      vert_if.valid <= 1'b0;
      vert_if.data  <= vert_t'({$urandom, $urandom});
      @(posedge clk_i);
    end
    vert_if.valid <= 1'b1;
    vert_if.data  <= v;
    do @(posedge clk_i); while (!vert_if.ready);
    track_vertex(v);
  endtask

  // Drop valid, wait for every pending pick, then let vertices that end no
  // list drain out of the pipe before anything touches the registers.
  task automatic settle();
    vert_if.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; leaves the write enable high for back-to-back writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ORIGIN_X: ray_cfg.origin_x = val;
      CFG_ORIGIN_Y: ray_cfg.origin_y = val;
      CFG_ORIGIN_Z: ray_cfg.origin_z = val;
      CFG_DIR_X:    ray_cfg.dir_x    = val[DIR_W-1:0];
      CFG_DIR_Y:    ray_cfg.dir_y    = val[DIR_W-1:0];
      CFG_DIR_Z:    ray_cfg.dir_z    = val[DIR_W-1:0];
      default: ;
    endcase
  endtask

  // Load all six ray registers; junk in the upper data bits of the
  // direction writes must be ignored.
  task automatic set_ray(input logic signed [COORD_W-1:0] ox, oy, oz,
                         input logic signed [DIR_W-1:0] sx, sy, sz);
    settle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, {8'($urandom), sx});
    write_reg(CFG_DIR_Y, {8'($urandom), sy});
    write_reg(CFG_DIR_Z, {8'($urandom), sz});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_ray();
    logic signed [COORD_W-1:0] o[3];
    logic signed [DIR_W-1:0]   s[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(5))
        0: o[i] = C_MIN;
        1: o[i] = C_MAX;
        default: o[i] = COORD_W'($urandom);
      endcase
      case ($urandom_range(5))
        0: s[i] = D_MIN;
        1: s[i] = D_MAX;
        default: s[i] = DIR_W'($urandom_range(254)) - 8'sd127;
      endcase
      if (s[i] == 0) s[i] = 8'sd1;
    end
    // Now and then knock out one direction component.
    if ($urandom_range(5) == 0) s[$urandom_range(2)] = '0;
    set_ray(o[0], o[1], o[2], s[0], s[1], s[2]);
  endtask

  // After reset dir_x and dir_y are zero, so nothing is found; writing just
  // those two must leave dir_z at its reset value of 127.
  task automatic test_reset_state();
    send_vertex(mk_vertex(16'sh0100, 16'sh0200, 16'sh0300, 1'b0));
    send_vertex(mk_vertex('0, '0, 16'sh0500, 1'b1));
    settle();
    write_reg(CFG_DIR_X, 16'h0003);
    write_reg(CFG_DIR_Y, 16'hfffb);
    cfg_we_i <= 1'b0;
    send_vertex(mk_vertex(16'sh0400, 16'sh0100, 16'sh0700, 1'b0));
    send_vertex(mk_vertex(16'sh0003, -16'sh0005, 16'sh007f, 1'b1));
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_unused_index();
    settle();
    for (int i = CFG_DIR_Z + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    send_vertex(mk_vertex(16'sh0040, -16'sh0010, 16'sh0900, 1'b1));
  endtask

  task automatic test_field_extremes();
    set_ray('0, '0, '0, D_MAX, D_MIN, 8'sd1);
    send_vertex(mk_vertex(C_MAX, C_MAX, C_MAX, 1'b0));
    send_vertex(mk_vertex(C_MIN, C_MIN, C_MIN, 1'b0));
    send_vertex(mk_vertex(C_MIN, C_MAX, '0, 1'b0));
    send_vertex(mk_vertex('0, '0, '0, 1'b0));
    send_vertex(mk_vertex('0, '0, '0, 1'b0));      // tie: earlier one wins
    send_vertex(mk_vertex(C_MAX, C_MIN, C_MAX, 1'b1));
    send_vertex(mk_vertex(C_MIN, C_MAX, C_MIN, 1'b1));  // one-vertex list
    set_ray(C_MIN, C_MAX, C_MIN, -8'sd127, 8'sd127, D_MIN);
    send_vertex(mk_vertex(C_MAX, C_MIN, C_MAX, 1'b0));
    send_vertex(mk_vertex(C_MIN, C_MAX, C_MIN, 1'b0));
    send_vertex(mk_vertex(C_MAX, C_MAX, C_MIN, 1'b1));
  endtask

  task automatic test_zero_direction();
    for (int i = 0; i < 3; i++) begin
      set_ray(16'sh0010, -16'sh0020, 16'sh0030,
              (i == 0) ? 8'sd0 : 8'sd5, (i == 1) ? 8'sd0 : -8'sd7, (i == 2) ? 8'sd0 : 8'sd9);
      send_vertex(random_vertex(1'b0));
      send_vertex(random_vertex(1'b1));
    end
  endtask

  // A register write inside a list applies from the next vertex on; a zero
  // direction written before the list end turns the result into not found.
  task automatic test_midlist_write();
    set_ray(16'sh0100, -16'sh0200, '0, 8'sd3, -8'sd5, 8'sd7);
    send_vertex(random_vertex(1'b0));
    send_vertex(random_vertex(1'b0));
    settle();
    write_reg(CFG_ORIGIN_Y, 16'h1234);
    cfg_we_i <= 1'b0;
    send_vertex(random_vertex(1'b0));
    send_vertex(random_vertex(1'b1));
    settle();
    send_vertex(random_vertex(1'b0));
    settle();
    write_reg(CFG_DIR_Y, '0);
    cfg_we_i <= 1'b0;
    send_vertex(random_vertex(1'b1));
  endtask

  // One list past the limit: the vertex at the limit sits on the line and
  // later ones on the line too, but those are dropped and the end mark
  // rides on a dropped vertex.
  task automatic test_list_limit();
    set_ray('0, '0, '0, 8'sd1, 8'sd1, 8'sd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int n = 1; n <= LIST_LIMIT + 5; n++) begin
      if (n >= LIST_LIMIT)
        send_vertex(mk_vertex(COORD_W'(n), COORD_W'(n), COORD_W'(n), n == LIST_LIMIT + 5));
      else
        send_vertex(mk_vertex(COORD_W'(n), COORD_W'(-n), '0, 1'b0));
    end
  endtask

  // Hold the result side off while vertices keep coming, so the queue fills
  // and input ready drops; then pause until every pick is in.
  task automatic test_backpressure();
    random_ray();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_off_go;
    repeat (40) send_vertex(random_vertex(1'b1));
    settle();
    recv_stall_pct = 51;
    -> hold_off_go;
    for (int n = 0; n < 60; n++) send_vertex(random_vertex($urandom_range(2) == 0));
    send_vertex(random_vertex(1'b1));
    settle();
  endtask

  // Random lists, mostly short, with the ray reloaded every few lists.
  task automatic test_random_lists(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned target);
    int unsigned taken;
    int unsigned lists;
    int unsigned len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    taken = 0;
    lists = 0;
    while (taken < target) begin
      if (lists % 8 == 0) random_ray();
      case ($urandom_range(19))
        0:       len = $urandom_range(120, 41);
        1, 2, 3: len = $urandom_range(40, 9);
        default: len = $urandom_range(8, 1);
      endcase
      for (int n = 1; n <= len; n++) send_vertex(random_vertex(n == len));
      taken += len;
      lists++;
    end
  endtask

  // Receiver: random stalls, forced low while a hold-off runs.
  always @(posedge clk_i) begin
    if (hold_active) pick_if.ready <= 1'b0;
    else pick_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Count out the hold-off in cycles.
  always begin
    @(hold_off_go);
    hold_active <= 1'b1;
    for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  // Compare every result transfer with the oldest pending pick.
  always @(posedge clk_i) begin : check_picks
    result_t want;
    if (rst_ni && pick_if.valid && pick_if.ready) begin
      if (expected_picks.size() == 0) begin
        log_mismatch("result with nothing pending", '0, pick_if.data);
      end else begin
        want = expected_picks.pop_front();
        if (pick_if.data.nearest_number !== want.nearest_number ||
            pick_if.data.found !== want.found)
          log_mismatch("wrong pick", want, pick_if.data);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    vert_if.valid  = 1'b0;
    vert_if.data   = '0;
    pick_if.ready  = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    prev_vertex    = '0;
    ray_cfg        = '0;
    ray_cfg.dir_z  = 8'sd127;
    open_list();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_unused_index();
    test_field_extremes();
    test_zero_direction();
    test_midlist_write();
    test_list_limit();
    test_backpressure();
    test_random_lists(0, 0, RANDOM_ITEMS / 4);
    test_random_lists(51, 0, RANDOM_ITEMS / 4);
    test_random_lists(0, 51, RANDOM_ITEMS / 4);
    test_random_lists(33, 33, RANDOM_ITEMS / 4);

    // Drain, then watch a little longer for stray results.
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_picks.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
